FILE: sv/falu_pkg.sv
// Shared opcode, class, status and tag types for the fixed-point ALU.
`timescale 1ns / 1ps

package falu_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_CMP    = 2'd1,
        CLS_MUL    = 2'd2,
        CLS_DIV    = 2'd3
    } cls_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        op_t  op;
        cls_t cls;
    } tag_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

FILE: sv/falu_front.sv
// Front end: accept a command word, classify its opcode, push it to the queue.
`timescale 1ns / 1ps

module falu_front
    import falu_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         queue_high,
    input  logic [3:0]   op,
    input  logic [W-1:0] operand_a,
    input  logic [W-1:0] operand_b,
    output logic         busy,
    output tag_t         push_tag,
    output logic [W-1:0] push_a,
    output logic [W-1:0] push_b
);

    logic         valid_reg;
    logic         valid_next;
    op_t          op_reg;
    cls_t         cls_reg;
    cls_t         cls_next;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;

    assign busy       = queue_high;
    assign valid_next = start && !queue_high;

    always_comb
    begin
        case (op_t'(op))
            OP_MUL:  cls_next = CLS_MUL;
            OP_DIV:  cls_next = CLS_DIV;
            OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE:
                     cls_next = CLS_CMP;
            default: cls_next = CLS_SIMPLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_next)
        begin
            op_reg  <= op_t'(op);
            cls_reg <= cls_next;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
    end

    assign push_tag.valid = valid_reg;
    assign push_tag.op    = op_reg;
    assign push_tag.cls   = cls_reg;
    assign push_a         = a_reg;
    assign push_b         = b_reg;

endmodule

FILE: sv/falu_queue.sv
// Short FIFO between the front end and the execution pipeline.
`timescale 1ns / 1ps

module falu_queue
    import falu_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  tag_t         push_tag,
    input  logic [W-1:0] push_a,
    input  logic [W-1:0] push_b,
    input  logic         pop,
    output tag_t         head_tag,
    output logic [W-1:0] head_a,
    output logic [W-1:0] head_b,
    output logic         queue_high
);

    op_t          op_mem [QUEUE_DEPTH];
    cls_t         cls_mem[QUEUE_DEPTH];
    logic [W-1:0] a_mem  [QUEUE_DEPTH];
    logic [W-1:0] b_mem  [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;

    assign push = push_tag.valid;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg]  <= push_tag.op;
            cls_mem[wr_ptr_reg] <= push_tag.cls;
            a_mem[wr_ptr_reg]   <= push_a;
            b_mem[wr_ptr_reg]   <= push_b;
        end
    end

    assign head_tag.valid = (count_reg != '0);
    assign head_tag.op    = op_mem[rd_ptr_reg];
    assign head_tag.cls   = cls_mem[rd_ptr_reg];
    assign head_a         = a_mem[rd_ptr_reg];
    assign head_b         = b_mem[rd_ptr_reg];
    assign queue_high     = (count_reg >= QCNT_W'(QUEUE_DEPTH - 2));

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> count_reg < QCNT_W'(QUEUE_DEPTH))
        else $error("queue pushed while full");

endmodule

FILE: sv/falu_back.sv
// Execution pipeline: simple ops, multiplier, bit-per-stage divider, rounding.
`timescale 1ns / 1ps

module falu_back
    import falu_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  tag_t         head_tag,
    input  logic [W-1:0] head_a,
    input  logic [W-1:0] head_b,
    output logic         pop,
    output logic         done,
    output logic [W-1:0] result,
    output logic         compare_true,
    output logic [1:0]   status
);

    localparam int QW = W + F;
    localparam int PW = ((2 * W + 1) > (QW + 1)) ? (2 * W + 1) : (QW + 1);
    localparam logic [W-1:0] SIGNBIT = {1'b1, {(W - 1){1'b0}}};
    localparam logic [W-1:0] MAXPOS  = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0] FI_LIM  = SIGNBIT >> F;
    localparam logic [2*W:0] HALF    = (2 * W + 1)'(1) << (F - 1);

    // Sign-apply a magnitude and saturate; bit W flags overflow.
    function automatic logic [W:0] pack_mag(input logic neg, input logic [PW-1:0] mag);
        logic [PW-1:0] sb;
        logic [PW-1:0] mp;
        logic [W-1:0]  lo;
        logic [W:0]    ret;
        sb = PW'(SIGNBIT);
        mp = PW'(MAXPOS);
        lo = mag[W-1:0];
        if (neg)
        begin
            ret = (mag > sb) ? {1'b1, SIGNBIT} : {1'b0, (~lo) + W'(1)};
        end
        else
        begin
            ret = (mag > mp) ? {1'b1, MAXPOS} : {1'b0, lo};
        end
        return ret;
    endfunction

    // ---------------- stage 0: decode and simple ops ----------------
    logic         na;
    logic         nb;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] sum;
    logic [W-1:0] dif;
    logic [W-1:0] sat_a;
    logic [W-1:0] fi_m2;
    logic [W-1:0] ti_m;
    logic         lt;
    logic         gt;
    logic         eq;
    logic [W:0]   fi_pack;

    tag_t         s0_tag_next;
    logic [W-1:0] s0_res_next;
    logic         s0_cmp_next;
    status_t      s0_st_next;

    tag_t         s0_tag_reg;
    logic [W-1:0] s0_res_reg;
    logic         s0_cmp_reg;
    status_t      s0_st_reg;
    logic         s0_neg_reg;
    logic [W-1:0] s0_ma_reg;
    logic [W-1:0] s0_mb_reg;

    assign pop   = head_tag.valid;
    assign na    = head_a[W-1];
    assign nb    = head_b[W-1];
    assign ma    = na ? ((~head_a) + W'(1)) : head_a;
    assign mb    = nb ? ((~head_b) + W'(1)) : head_b;
    assign sum   = head_a + head_b;
    assign dif   = head_a - head_b;
    assign sat_a = na ? SIGNBIT : MAXPOS;
    assign lt    = $signed(head_a) < $signed(head_b);
    assign gt    = $signed(head_a) > $signed(head_b);
    assign eq    = (head_a == head_b);
    assign fi_m2 = ma << F;
    assign ti_m  = ma >> F;
    assign fi_pack = pack_mag(na, PW'(fi_m2));

    always_comb
    begin
        s0_tag_next = head_tag;
        s0_res_next = '0;
        s0_cmp_next = 1'b0;
        s0_st_next  = ST_OK;
        case (head_tag.op)
            OP_ADD:
            begin
                if ((na == nb) && (sum[W-1] != na))
                begin
                    s0_res_next = sat_a;
                    s0_st_next  = ST_OVF;
                end
                else
                begin
                    s0_res_next = sum;
                end
            end
            OP_SUB:
            begin
                if ((na != nb) && (dif[W-1] != na))
                begin
                    s0_res_next = sat_a;
                    s0_st_next  = ST_OVF;
                end
                else
                begin
                    s0_res_next = dif;
                end
            end
            OP_INC:
            begin
                if (head_a == MAXPOS)
                begin
                    s0_res_next = MAXPOS;
                    s0_st_next  = ST_OVF;
                end
                else
                begin
                    s0_res_next = head_a + W'(1);
                end
            end
            OP_DEC:
            begin
                if (head_a == SIGNBIT)
                begin
                    s0_res_next = SIGNBIT;
                    s0_st_next  = ST_OVF;
                end
                else
                begin
                    s0_res_next = head_a - W'(1);
                end
            end
            OP_GT:  s0_cmp_next = gt;
            OP_LT:  s0_cmp_next = lt;
            OP_GE:  s0_cmp_next = !lt;
            OP_LE:  s0_cmp_next = !gt;
            OP_EQ:  s0_cmp_next = eq;
            OP_NE:  s0_cmp_next = !eq;
            OP_MIN: s0_res_next = lt ? head_a : head_b;
            OP_MAX: s0_res_next = gt ? head_a : head_b;
            OP_FROM_INT:
            begin
                if (ma > FI_LIM)
                begin
                    s0_res_next = sat_a;
                    s0_st_next  = ST_OVF;
                end
                else
                begin
                    s0_res_next = fi_pack[W-1:0];
                    s0_st_next  = fi_pack[W] ? ST_OVF : ST_OK;
                end
            end
            OP_TO_INT: s0_res_next = na ? ((~ti_m) + W'(1)) : ti_m;
            default:   s0_res_next = '0;
        endcase
        // divide by zero bypasses the divider entirely
        if ((head_tag.cls == CLS_DIV) && (mb == '0))
        begin
            s0_res_next     = '0;
            s0_st_next      = ST_DIV0;
            s0_tag_next.cls = CLS_SIMPLE;
        end
    end

    // ---------------- stage 1: multiply ----------------
    tag_t         s1_tag_reg;
    logic [W-1:0] s1_res_reg;
    logic         s1_cmp_reg;
    status_t      s1_st_reg;
    logic         s1_neg_reg;
    logic [W-1:0] s1_ma_reg;
    logic [W-1:0] s1_mb_reg;
    logic [2*W-1:0] s1_prod_reg;

    // ---------------- stage 2 onward: round product, divide ----------------
    logic [2*W:0] mul_sum;
    logic [W:0]   mul_pack;

    tag_t         dv_tag_reg [0:QW];
    logic [W-1:0] dv_res_reg [0:QW];
    logic         dv_cmp_reg [0:QW];
    status_t      dv_st_reg  [0:QW];
    logic         dv_neg_reg [0:QW];
    logic [W-1:0] dv_mb_reg  [0:QW];
    logic [W-1:0] dv_r_reg   [0:QW];
    logic [QW-1:0] dv_nq_reg [0:QW];

    logic [W-1:0]  dv_r_next  [0:QW-1];
    logic [QW-1:0] dv_nq_next [0:QW-1];

    assign mul_sum  = {1'b0, s1_prod_reg} + HALF;
    assign mul_pack = pack_mag(s1_neg_reg, PW'(mul_sum >> F));

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            logic [W:0] r2;
            r2 = {dv_r_reg[k], dv_nq_reg[k][QW-1]};
            if (r2 >= {1'b0, dv_mb_reg[k]})
            begin
                dv_r_next[k]  = W'(r2 - {1'b0, dv_mb_reg[k]});
                dv_nq_next[k] = {dv_nq_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                dv_r_next[k]  = r2[W-1:0];
                dv_nq_next[k] = {dv_nq_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    // ---------------- output: divide rounding ----------------
    logic         rnd;
    logic [QW:0]  div_q;
    logic [W:0]   div_pack;
    logic [W-1:0] out_res_next;
    status_t      out_st_next;

    logic         done_reg;
    logic [W-1:0] result_reg;
    logic         cmp_reg;
    status_t      st_reg;

    assign rnd      = {dv_r_reg[QW], 1'b0} >= {1'b0, dv_mb_reg[QW]};
    assign div_q    = {1'b0, dv_nq_reg[QW]} + (QW + 1)'(rnd);
    assign div_pack = pack_mag(dv_neg_reg[QW], PW'(div_q));

    always_comb
    begin
        if (dv_tag_reg[QW].cls == CLS_DIV)
        begin
            out_res_next = div_pack[W-1:0];
            out_st_next  = div_pack[W] ? ST_OVF : ST_OK;
        end
        else
        begin
            out_res_next = dv_res_reg[QW];
            out_st_next  = dv_st_reg[QW];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg <= '0;
            s1_tag_reg <= '0;
            for (int k = 0; k <= QW; k++)
            begin
                dv_tag_reg[k] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s0_tag_reg    <= s0_tag_next;
            s1_tag_reg    <= s0_tag_reg;
            dv_tag_reg[0] <= s1_tag_reg;
            for (int k = 0; k < QW; k++)
            begin
                dv_tag_reg[k+1] <= dv_tag_reg[k];
            end
            done_reg <= dv_tag_reg[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_res_reg     <= s0_res_next;
        s0_cmp_reg     <= s0_cmp_next;
        s0_st_reg      <= s0_st_next;
        s0_neg_reg     <= na ^ nb;
        s0_ma_reg      <= ma;
        s0_mb_reg      <= mb;

        s1_res_reg     <= s0_res_reg;
        s1_cmp_reg     <= s0_cmp_reg;
        s1_st_reg      <= s0_st_reg;
        s1_neg_reg     <= s0_neg_reg;
        s1_ma_reg      <= s0_ma_reg;
        s1_mb_reg      <= s0_mb_reg;
        s1_prod_reg    <= s0_ma_reg * s0_mb_reg;

        dv_cmp_reg[0]     <= s1_cmp_reg;
        dv_neg_reg[0]     <= s1_neg_reg;
        dv_mb_reg[0]      <= s1_mb_reg;
        dv_r_reg[0]       <= '0;
        dv_nq_reg[0]      <= {s1_ma_reg, {F{1'b0}}};
        if (s1_tag_reg.cls == CLS_MUL)
        begin
            dv_res_reg[0] <= mul_pack[W-1:0];
            dv_st_reg[0]  <= mul_pack[W] ? ST_OVF : ST_OK;
        end
        else
        begin
            dv_res_reg[0] <= s1_res_reg;
            dv_st_reg[0]  <= s1_st_reg;
        end

        for (int k = 0; k < QW; k++)
        begin
            dv_res_reg[k+1]     <= dv_res_reg[k];
            dv_cmp_reg[k+1]     <= dv_cmp_reg[k];
            dv_st_reg[k+1]      <= dv_st_reg[k];
            dv_neg_reg[k+1]     <= dv_neg_reg[k];
            dv_mb_reg[k+1]      <= dv_mb_reg[k];
            dv_r_reg[k+1]       <= dv_r_next[k];
            dv_nq_reg[k+1]      <= dv_nq_next[k];
        end

        result_reg <= out_res_next;
        cmp_reg    <= dv_cmp_reg[QW];
        st_reg     <= out_st_next;
    end

    assign done         = done_reg;
    assign result       = result_reg;
    assign compare_true = cmp_reg;
    assign status       = st_reg;

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s0_tag_reg.valid |-> ##(QW + 3) done_reg)
        else $error("word lost in execution pipeline");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && st_reg == ST_DIV0) |-> (result_reg == '0 && !cmp_reg))
        else $error("divide by zero word carries data");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && cmp_reg) |-> (result_reg == '0 && st_reg == ST_OK))
        else $error("compare word carries result or status");

endmodule

FILE: sv/fixed_point_q24_8_alu.sv
// Top level of the signed fixed-point ALU: front end, queue and execution pipeline.
// A Q24.8 word passes the front register, queue, decode, multiply, divider stages and
//   output register; the one-bit-per-stage divider sets that depth for every opcode.
// Throughput: one word per cycle, every opcode; busy only rises if the queue backs up.
// Results appear for exactly one cycle with done high; the receiver cannot stall them.
// Reset (rst_n low, asynchronous) empties the queue and drops every word in flight.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu
    import falu_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   op,
    input  logic signed [DATA_WIDTH-1:0] operand_a,
    input  logic signed [DATA_WIDTH-1:0] operand_b,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result,
    output logic                         compare_true,
    output logic [1:0]                   status
);

    // front end to queue
    tag_t                  push_tag;
    logic [DATA_WIDTH-1:0] push_a;
    logic [DATA_WIDTH-1:0] push_b;
    logic                  queue_high;

    // queue to execution pipeline
    tag_t                  head_tag;
    logic [DATA_WIDTH-1:0] head_a;
    logic [DATA_WIDTH-1:0] head_b;
    logic                  pop;
    logic [DATA_WIDTH-1:0] result_raw;

    // Accept and classify; register the word before it enters the queue.
    falu_front #(
        .W(DATA_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .queue_high (queue_high),
        .op         (op),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .busy       (busy),
        .push_tag   (push_tag),
        .push_a     (push_a),
        .push_b     (push_b)
    );

    // Decouple the two halves; the pipeline drains one word each cycle.
    falu_queue #(
        .W(DATA_WIDTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_tag   (push_tag),
        .push_a     (push_a),
        .push_b     (push_b),
        .pop        (pop),
        .head_tag   (head_tag),
        .head_a     (head_a),
        .head_b     (head_b),
        .queue_high (queue_high)
    );

    // Fixed-depth execution: every opcode rides the same stages, so order holds.
    falu_back #(
        .W(DATA_WIDTH),
        .F(FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_tag     (head_tag),
        .head_a       (head_a),
        .head_b       (head_b),
        .pop          (pop),
        .done         (done),
        .result       (result_raw),
        .compare_true (compare_true),
        .status       (status)
    );

    assign result = $signed(result_raw);

endmodule
